### sv/adam_optimizer_update_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the Adam update block.
// ----------------------------------------------------------------------------
`ifndef ADAM_OPTIMIZER_UPDATE_MACROS_SVH
`define ADAM_OPTIMIZER_UPDATE_MACROS_SVH

// check a condition in the same cycle as its trigger
`define ADAM_ASSERT_NOW(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error(msg);

// check a condition in the cycle after its trigger
`define ADAM_ASSERT_NEXT(label, ck, rs, ante, cons, msg) \
  label: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/adam_pkg.sv
// ----------------------------------------------------------------------------
// adam_pkg
// Constants and pipeline stage types of the Adam parameter update block.
// ----------------------------------------------------------------------------
`default_nettype none

package adam_pkg;

  localparam int ELEMENTS_DEF = 1024;

  localparam int IDX_W      = 10;
  localparam int DATA_W     = 32;
  localparam int COEF_W     = 31;
  localparam int EPS_W      = 16;
  localparam int APB_ADDR_W = 4;

  localparam logic [31:0] ONE_Q31     = 32'h8000_0000;
  localparam logic [32:0] DELTA_CLIP  = 33'h1_0000_0000;
  localparam logic [32:0] DELTA_LIMIT = 33'd167772;

  localparam logic [1:0] REG_STEP_SIZE    = 2'd0;
  localparam logic [1:0] REG_FIRST_DECAY  = 2'd1;
  localparam logic [1:0] REG_SECOND_DECAY = 2'd2;
  localparam logic [1:0] REG_EPSILON      = 2'd3;

  localparam logic [COEF_W-1:0] STEP_SIZE_RST    = 31'd21474836;
  localparam logic [COEF_W-1:0] FIRST_DECAY_RST  = 31'd1932735283;
  localparam logic [COEF_W-1:0] SECOND_DECAY_RST = 31'd2145336164;
  localparam logic [EPS_W-1:0]  EPSILON_RST      = 16'd21;

  // stage counts of the bias divide, square root and step divide
  localparam int NB = 31;
  localparam int NQ = 32;
  localparam int ND = 33;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] g;
    logic signed [DATA_W-1:0] theta;
    logic [31:0]              p1;
    logic [31:0]              p2;
  } front_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] theta;
    logic [31:0]              p1;
    logic [31:0]              p2;
    logic signed [63:0]       tm;
    logic [30:0]              g2;
  } pre_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] theta;
    logic [31:0]              p1;
    logic [31:0]              p2;
    logic signed [DATA_W-1:0] m;
    logic [62:0]              tv;
  } mom_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] theta;
    logic [31:0]              p1;
    logic [31:0]              p2;
    logic signed [DATA_W-1:0] m;
    logic [30:0]              v;
  } mv_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] theta;
    logic                     neg;
    logic                     sat1;
    logic                     sat2;
    logic [31:0]              d1;
    logic [31:0]              d2;
    logic [31:0]              r1;
    logic [31:0]              r2;
    logic [30:0]              q1;
    logic [30:0]              q2;
  } bias_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] theta;
    logic                     neg;
    logic [62:0]              num;
    logic [31:0]              xs;
    logic [33:0]              rem;
    logic [31:0]              root;
  } root_t;

  typedef struct packed {
    logic [IDX_W-1:0]         idx;
    logic signed [DATA_W-1:0] theta;
    logic                     neg;
    logic                     sat;
    logic [35:0]              den;
    logic [35:0]              r;
    logic [32:0]              lo;
    logic [32:0]              q;
  } quo_t;

endpackage

`default_nettype wire

### sv/adam_optimizer_update.sv
// ----------------------------------------------------------------------------
// adam_optimizer_update
// Element-wise Adam update in fixed point with moment stores in block RAM.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Payload
// request  in   in_valid/in_ready    element_index gradient param_in new_step
// result   out  out_valid/out_ready  index_out param_out step_too_large
// config   in   APB psel/penable     paddr pwdata prdata pready
//
// One request per cycle while no result is held and no clearing pass runs; the
// rate is set by the moment read-modify-write loops, one multiply-add per moment
// store per cycle with write forwarding.
// After reset, a clearing pass zeroes every slot of both moment stores;
// in_ready stays low meanwhile.
// A held result freezes the whole pipeline, including the store ports.
// ----------------------------------------------------------------------------
`default_nettype none

`include "adam_optimizer_update_macros.svh"

module adam_optimizer_update #(
  parameter int ELEMENTS = adam_pkg::ELEMENTS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [adam_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [adam_pkg::IDX_W-1:0]          element_index,
  input  logic signed [adam_pkg::DATA_W-1:0]  gradient,
  input  logic signed [adam_pkg::DATA_W-1:0]  param_in,
  input  logic                                new_step,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [adam_pkg::IDX_W-1:0]          index_out,
  output logic signed [adam_pkg::DATA_W-1:0]  param_out,
  output logic                                step_too_large
);

  localparam int ADDR_W = (ELEMENTS > 1) ? $clog2(ELEMENTS) : 1;
  localparam int NB = adam_pkg::NB;
  localparam int NQ = adam_pkg::NQ;
  localparam int ND = adam_pkg::ND;
  localparam int IDX_W = adam_pkg::IDX_W;

  function automatic logic [ADDR_W-1:0] slot_of(input logic [IDX_W-1:0] idx);
    logic [IDX_W:0] r;
    r = {1'b0, idx};
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (64'(r) >= (64'(ELEMENTS) << k)) begin
        r = (IDX_W + 1)'(64'(r) - (64'(ELEMENTS) << k));
      end
    end
    return ADDR_W'(r);
  endfunction

  function automatic adam_pkg::bias_t bias_step(input adam_pkg::bias_t b);
    adam_pkg::bias_t n;
    logic [32:0] r1x;
    logic [32:0] r2x;
    logic ge1;
    logic ge2;
    n = b;
    r1x = {b.r1, 1'b0};
    r2x = {b.r2, 1'b0};
    ge1 = r1x >= {1'b0, b.d1};
    ge2 = r2x >= {1'b0, b.d2};
    n.r1 = ge1 ? 32'(r1x - {1'b0, b.d1}) : r1x[31:0];
    n.r2 = ge2 ? 32'(r2x - {1'b0, b.d2}) : r2x[31:0];
    n.q1 = {b.q1[29:0], ge1};
    n.q2 = {b.q2[29:0], ge2};
    return n;
  endfunction

  function automatic adam_pkg::root_t root_step(input adam_pkg::root_t b);
    adam_pkg::root_t n;
    logic [35:0] rx;
    logic [35:0] t;
    logic ge;
    n = b;
    rx = {b.rem, b.xs[31:30]};
    t = {2'b00, b.root, 2'b01};
    ge = rx >= t;
    n.rem = ge ? 34'(rx - t) : rx[33:0];
    n.root = {b.root[30:0], ge};
    n.xs = {b.xs[29:0], 2'b00};
    return n;
  endfunction

  function automatic adam_pkg::quo_t quo_step(input adam_pkg::quo_t b);
    adam_pkg::quo_t n;
    logic [36:0] rx;
    logic ge;
    n = b;
    rx = {b.r, b.lo[32]};
    ge = rx >= {1'b0, b.den};
    n.r = ge ? 36'(rx - {1'b0, b.den}) : rx[35:0];
    n.lo = {b.lo[31:0], 1'b0};
    n.q = {b.q[31:0], ge};
    return n;
  endfunction

  // configuration
  logic [adam_pkg::COEF_W-1:0] step_size;
  logic [adam_pkg::COEF_W-1:0] first_decay;
  logic [adam_pkg::COEF_W-1:0] second_decay;
  logic [adam_pkg::EPS_W-1:0]  epsilon_term;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_size    <= adam_pkg::STEP_SIZE_RST;
      first_decay  <= adam_pkg::FIRST_DECAY_RST;
      second_decay <= adam_pkg::SECOND_DECAY_RST;
      epsilon_term <= adam_pkg::EPSILON_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        adam_pkg::REG_STEP_SIZE:    step_size    <= pwdata[30:0];
        adam_pkg::REG_FIRST_DECAY:  first_decay  <= pwdata[30:0];
        adam_pkg::REG_SECOND_DECAY: second_decay <= pwdata[30:0];
        adam_pkg::REG_EPSILON:      epsilon_term <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      adam_pkg::REG_STEP_SIZE:    prdata = {1'b0, step_size};
      adam_pkg::REG_FIRST_DECAY:  prdata = {1'b0, first_decay};
      adam_pkg::REG_SECOND_DECAY: prdata = {1'b0, second_decay};
      adam_pkg::REG_EPSILON:      prdata = {16'h0000, epsilon_term};
      default:                    prdata = '0;
    endcase
  end

  // control
  logic              adv;
  logic              accept;
  logic              clearing;
  logic [ADDR_W-1:0] clr_addr;
  logic [3:0]        vld_front;
  logic [NB:0]       vld_b;
  logic [NQ:0]       vld_q;
  logic [ND:0]       vld_d;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && !clearing;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      if (clr_addr == ADDR_W'(ELEMENTS - 1)) begin
        clearing <= 1'b0;
      end else begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_front <= '0;
      vld_b     <= '0;
      vld_q     <= '0;
      vld_d     <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      vld_front <= {vld_front[2:0], accept};
      vld_b     <= {vld_b[NB-1:0], vld_front[3]};
      vld_q     <= {vld_q[NQ-1:0], vld_b[NB]};
      vld_d     <= {vld_d[ND-1:0], vld_q[NQ]};
      out_valid <= vld_d[ND];
    end
  end

  // decay powers
  logic [31:0] p1;
  logic [31:0] p2;
  logic [31:0] p1_next;
  logic [31:0] p2_next;

  assign p1_next = new_step ? 32'((64'(p1) * 64'(first_decay)) >> 31) : p1;
  assign p2_next = new_step ? 32'((64'(p2) * 64'(second_decay)) >> 31) : p2;

  always_ff @(posedge clk) begin
    if (rst) begin
      p1 <= adam_pkg::ONE_Q31;
      p2 <= adam_pkg::ONE_Q31;
    end else if (accept) begin
      p1 <= p1_next;
      p2 <= p2_next;
    end
  end

  // front stages
  adam_pkg::front_t  s0;
  adam_pkg::pre_t    s1;
  adam_pkg::mom_t    s2;
  adam_pkg::mv_t     s3;
  logic [ADDR_W-1:0] slot0;
  logic [ADDR_W-1:0] slot1;
  logic [ADDR_W-1:0] slot2;

  logic [31:0]        gm;
  logic [63:0]        gsq;
  logic [30:0]        g2_c;
  logic [31:0]        c1;
  logic signed [63:0] tm_c;
  logic [31:0]        c2;
  logic [62:0]        tv_c;

  always_comb begin
    gm   = s0.g[31] ? 32'(-s0.g) : 32'(s0.g);
    gsq  = 64'(gm) * 64'(gm);
    g2_c = (gsq[63:24] > 40'h00_7FFF_FFFF) ? 31'h7FFF_FFFF : gsq[54:24];
    c1   = adam_pkg::ONE_Q31 - {1'b0, first_decay};
    tm_c = $signed({32'h0, c1}) * 64'(s0.g);
    c2   = adam_pkg::ONE_Q31 - {1'b0, second_decay};
    tv_c = 63'(c2) * 63'(s1.g2);
  end

  // moment stores
  logic signed [31:0] mem1 [ELEMENTS];
  logic [30:0]        mem2 [ELEMENTS];
  logic signed [31:0] rd1;
  logic [30:0]        rd2;
  logic               fwd1_vld;
  logic [ADDR_W-1:0]  fwd1_slot;
  logic signed [31:0] fwd1_data;
  logic               fwd2_vld;
  logic [ADDR_W-1:0]  fwd2_slot;
  logic [30:0]        fwd2_data;

  logic signed [31:0] m_old;
  logic signed [64:0] m_sum;
  logic signed [64:0] m_sh;
  logic signed [31:0] m_new;
  logic [30:0]        v_old;
  logic [63:0]        v_sum;
  logic [32:0]        v_sh;
  logic [30:0]        v_new;

  always_comb begin
    m_old = (fwd1_vld && (fwd1_slot == slot1)) ? fwd1_data : rd1;
    m_sum = $signed({34'h0, first_decay}) * 65'(m_old) + 65'(s1.tm);
    m_sh  = m_sum >>> 31;
    if (m_sh > 65'sh0_7FFF_FFFF) begin
      m_new = 32'sh7FFF_FFFF;
    end else if (m_sh < -65'sh0_8000_0000) begin
      m_new = 32'sh8000_0000;
    end else begin
      m_new = m_sh[31:0];
    end
    v_old = (fwd2_vld && (fwd2_slot == slot2)) ? fwd2_data : rd2;
    v_sum = 64'(second_decay) * 64'(v_old) + 64'(s2.tv);
    v_sh  = v_sum[63:31];
    v_new = (v_sh > 33'h0_7FFF_FFFF) ? 31'h7FFF_FFFF : v_sh[30:0];
  end

  logic               wr1_en;
  logic [ADDR_W-1:0]  wr1_addr;
  logic signed [31:0] wr1_data;
  logic               wr2_en;
  logic [ADDR_W-1:0]  wr2_addr;
  logic [30:0]        wr2_data;

  assign wr1_en   = clearing || (adv && vld_front[1]);
  assign wr1_addr = clearing ? clr_addr : slot1;
  assign wr1_data = clearing ? '0 : m_new;
  assign wr2_en   = clearing || (adv && vld_front[2]);
  assign wr2_addr = clearing ? clr_addr : slot2;
  assign wr2_data = clearing ? '0 : v_new;

  always_ff @(posedge clk) begin
    if (wr1_en) begin
      mem1[wr1_addr] <= wr1_data;
    end
    if (adv) begin
      rd1 <= mem1[slot0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr2_en) begin
      mem2[wr2_addr] <= wr2_data;
    end
    if (adv) begin
      rd2 <= mem2[slot1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd1_vld <= 1'b0;
      fwd2_vld <= 1'b0;
    end else if (adv) begin
      fwd1_vld <= vld_front[1];
      fwd2_vld <= vld_front[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fwd1_slot <= slot1;
      fwd1_data <= m_new;
      fwd2_slot <= slot2;
      fwd2_data <= v_new;

      s0.idx   <= element_index;
      s0.g     <= gradient;
      s0.theta <= param_in;
      s0.p1    <= p1_next;
      s0.p2    <= p2_next;
      slot0    <= slot_of(element_index);

      s1.idx   <= s0.idx;
      s1.theta <= s0.theta;
      s1.p1    <= s0.p1;
      s1.p2    <= s0.p2;
      s1.tm    <= tm_c;
      s1.g2    <= g2_c;
      slot1    <= slot0;

      s2.idx   <= s1.idx;
      s2.theta <= s1.theta;
      s2.p1    <= s1.p1;
      s2.p2    <= s1.p2;
      s2.m     <= m_new;
      s2.tv    <= tv_c;
      slot2    <= slot1;

      s3.idx   <= s2.idx;
      s3.theta <= s2.theta;
      s3.p1    <= s2.p1;
      s3.p2    <= s2.p2;
      s3.m     <= s2.m;
      s3.v     <= v_new;
    end
  end

  // bias correction divide
  adam_pkg::bias_t bs [NB+1];
  adam_pkg::bias_t b_init;
  logic [31:0]     mag1;
  logic [31:0]     mag2;

  always_comb begin
    mag1          = s3.m[31] ? 32'(-s3.m) : 32'(s3.m);
    mag2          = {1'b0, s3.v};
    b_init.idx    = s3.idx;
    b_init.theta  = s3.theta;
    b_init.neg    = s3.m[31];
    b_init.d1     = s3.p1[31] ? adam_pkg::ONE_Q31 : adam_pkg::ONE_Q31 - s3.p1;
    b_init.d2     = s3.p2[31] ? adam_pkg::ONE_Q31 : adam_pkg::ONE_Q31 - s3.p2;
    b_init.sat1   = mag1 >= b_init.d1;
    b_init.sat2   = mag2 >= b_init.d2;
    b_init.r1     = mag1;
    b_init.r2     = mag2;
    b_init.q1     = '0;
    b_init.q2     = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bs[0] <= b_init;
    end
  end

  for (genvar k = 0; k < NB; k++) begin : g_bias
    always_ff @(posedge clk) begin
      if (adv) begin
        bs[k+1] <= bias_step(bs[k]);
      end
    end
  end

  // square root
  adam_pkg::root_t sq [NQ+1];
  adam_pkg::root_t q_init;
  logic [31:0]     mh_mag;
  logic [30:0]     vh;

  always_comb begin
    if (bs[NB].sat1) begin
      mh_mag = bs[NB].neg ? adam_pkg::ONE_Q31 : 32'h7FFF_FFFF;
    end else begin
      mh_mag = {1'b0, bs[NB].q1};
    end
    vh           = bs[NB].sat2 ? 31'h7FFF_FFFF : bs[NB].q2;
    q_init.idx   = bs[NB].idx;
    q_init.theta = bs[NB].theta;
    q_init.neg   = bs[NB].neg;
    q_init.num   = 63'(step_size) * 63'(mh_mag);
    q_init.xs    = {1'b0, vh};
    q_init.rem   = '0;
    q_init.root  = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq[0] <= q_init;
    end
  end

  for (genvar k = 0; k < NQ; k++) begin : g_root
    always_ff @(posedge clk) begin
      if (adv) begin
        sq[k+1] <= root_step(sq[k]);
      end
    end
  end

  // step divide
  adam_pkg::quo_t dv [ND+1];
  adam_pkg::quo_t d_init;
  logic [35:0]    den_raw;

  always_comb begin
    den_raw      = {1'b0, sq[NQ].root, 3'b000} + 36'(epsilon_term);
    d_init.idx   = sq[NQ].idx;
    d_init.theta = sq[NQ].theta;
    d_init.neg   = sq[NQ].neg;
    d_init.den   = (den_raw == '0) ? 36'd1 : den_raw;
    d_init.sat   = {6'h00, sq[NQ].num[62:33]} >= d_init.den;
    d_init.r     = {6'h00, sq[NQ].num[62:33]};
    d_init.lo    = sq[NQ].num[32:0];
    d_init.q     = '0;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dv[0] <= d_init;
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_quo
    always_ff @(posedge clk) begin
      if (adv) begin
        dv[k+1] <= quo_step(dv[k]);
      end
    end
  end

  // result
  logic [32:0]        qc;
  logic signed [34:0] dlt;
  logic signed [34:0] diff;
  logic signed [31:0] res;

  always_comb begin
    qc = (dv[ND].sat || (dv[ND].q > adam_pkg::DELTA_CLIP)) ? adam_pkg::DELTA_CLIP : dv[ND].q;
    dlt = dv[ND].neg ? -$signed({2'b00, qc}) : $signed({2'b00, qc});
    diff = $signed({{3{dv[ND].theta[31]}}, dv[ND].theta}) - dlt;
    if (diff > 35'sh0_7FFF_FFFF) begin
      res = 32'sh7FFF_FFFF;
    end else if (diff < -35'sh0_8000_0000) begin
      res = 32'sh8000_0000;
    end else begin
      res = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      index_out      <= dv[ND].idx;
      param_out      <= res;
      step_too_large <= !dv[ND].neg && (qc > adam_pkg::DELTA_LIMIT);
    end
  end

  `ADAM_ASSERT_NOW(a_clear_empty, clk, rst, clearing, ~|{vld_front, vld_b}, "busy in clear")
  `ADAM_ASSERT_NEXT(a_stall_freeze, clk, rst, !adv, $stable({vld_b, vld_q, vld_d}), "stall moved")
  `ADAM_ASSERT_NEXT(a_power_decay, clk, rst, accept, p1 <= $past(p1) && p2 <= $past(p2), "power rose")
  `ADAM_ASSERT_NEXT(a_fwd_track, clk, rst, adv && vld_front[1],
                    fwd1_vld && fwd1_slot == $past(slot1), "forward lost")

endmodule

`default_nettype wire
